[design/scb_pkg.sv]
// Shared constants, types and the bar table of the scrolling color bar generator.
package scb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;
  localparam int WORD_W  = 32;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int PAIRS_W = 12;
  localparam int BAR_W   = 3;
  localparam int CNT_W   = 4;

  localparam int MOD_STEPS = COL_W;
  localparam int BAR_STEPS = BAR_W;

  localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic load;
    logic step_mod;
    logic save_a;
    logic sum;
    logic step_bar;
    logic emit;
  } scb_cmd_t;

  typedef struct packed {
    logic odd_width;
    logic out_free;
  } scb_sts_t;

  function automatic logic [WORD_W-1:0] bar_word(input logic [BAR_W-1:0] bar);
    logic [WORD_W-1:0] w;
    case (bar)
      3'd0:    w = {8'd128, 8'd235, 8'd128, 8'd235};
      3'd1:    w = {8'd138, 8'd219, 8'd16,  8'd219};
      3'd2:    w = {8'd16,  8'd188, 8'd154, 8'd188};
      3'd3:    w = {8'd26,  8'd173, 8'd42,  8'd173};
      3'd4:    w = {8'd230, 8'd78,  8'd214, 8'd78};
      3'd5:    w = {8'd240, 8'd63,  8'd102, 8'd63};
      3'd6:    w = {8'd118, 8'd32,  8'd240, 8'd32};
      default: w = {8'd128, 8'd16,  8'd128, 8'd16};
    endcase
    return w;
  endfunction

endpackage

[design/scb_in_if.sv]
// Input word channel: restart request.
interface scb_in_if;
  logic valid;
  logic ready;
  logic restart_frame;

  modport source (output valid, output restart_frame, input ready);
  modport sink (input valid, input restart_frame, output ready);
endinterface

[design/scb_out_if.sv]
// Output word channel: one YUYV pixel pair with line/frame markers.
interface scb_out_if;
  logic                      valid;
  logic                      ready;
  logic [scb_pkg::WORD_W-1:0] pixel_pair_word;
  logic                      line_last;
  logic                      frame_last;
  logic                      odd_width_error;

  modport source (output valid, output pixel_pair_word, output line_last,
                  output frame_last, output odd_width_error, input ready);
  modport sink (input valid, input pixel_pair_word, input line_last,
                input frame_last, input odd_width_error, output ready);
endinterface

[design/scb_ctrl.sv]
// Sequencer: steps the shared remainder/divide unit through one pixel pair.
module scb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scb_pkg::scb_sts_t sts,
  output scb_pkg::scb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MODA  = 3'd1;
  localparam logic [2:0] S_SAVEA = 3'd2;
  localparam logic [2:0] S_MODB  = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_BAR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [scb_pkg::CNT_W-1:0] MOD_LAST = scb_pkg::CNT_W'(scb_pkg::MOD_STEPS - 1);
  localparam logic [scb_pkg::CNT_W-1:0] BAR_LAST = scb_pkg::CNT_W'(scb_pkg::BAR_STEPS - 1);

  logic [2:0]                state_r, state_nxt;
  logic [scb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.odd_width ? S_DONE : S_MODA;
        end
      end
      S_MODA: begin
        cmd.step_mod = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MOD_LAST) state_nxt = S_SAVEA;
      end
      S_SAVEA: begin
        cmd.save_a = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_MODB;
      end
      S_MODB: begin
        cmd.step_mod = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MOD_LAST) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_BAR;
      end
      S_BAR: begin
        cmd.step_bar = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == BAR_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[design/scb_dp.sv]
// Datapath: config, raster position, scroll, remainder/divide step unit, output register.
module scb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [scb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_restart_frame,
  input  scb_pkg::scb_cmd_t             cmd,
  output scb_pkg::scb_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scb_pkg::WORD_W-1:0]    out_pixel_pair_word,
  output logic                          out_line_last,
  output logic                          out_frame_last,
  output logic                          out_odd_width_error
);

  localparam logic [scb_pkg::CFG_W-1:0] WIDTH_CAP  = scb_pkg::CFG_W'(scb_pkg::MAX_WIDTH);
  localparam logic [scb_pkg::CFG_W-1:0] HEIGHT_CAP = scb_pkg::CFG_W'(scb_pkg::MAX_HEIGHT);

  logic [scb_pkg::CFG_W-1:0]   width_r, height_r;
  logic [scb_pkg::COL_W-1:0]   col_r, so_r, so_lat_r, dvd_r, a_r, rem_r;
  logic [scb_pkg::ROW_W-1:0]   row_r;
  logic [scb_pkg::PAIRS_W-1:0] pairs_r;
  logic [scb_pkg::BAR_W-1:0]   quot_r;
  logic                        eol_r, eof_r, err_r;
  logic                        out_valid_r, line_last_r, frame_last_r, odd_err_r;
  logic [scb_pkg::WORD_W-1:0]  word_r;

  logic                        odd;
  logic [scb_pkg::CFG_W-1:0]   width_sat, height_sat, height_m1;
  logic [scb_pkg::PAIRS_W-1:0] pairs, pairs_m1, so_inc, trial, sum_raw;
  logic [scb_pkg::COL_W-1:0]   col_cur, so_cur, so_next, rem_step, sum_red;
  logic [scb_pkg::ROW_W-1:0]   row_cur;
  logic                        eol, eof, step_bit, ge;

  assign odd        = (width_r == '0) || width_r[0];
  assign width_sat  = (width_r > WIDTH_CAP) ? WIDTH_CAP : width_r;
  assign pairs      = width_sat[scb_pkg::CFG_W-1:1];
  assign pairs_m1   = pairs - 1'b1;
  assign height_sat = (height_r == '0) ? scb_pkg::CFG_W'(1) :
                      ((height_r > HEIGHT_CAP) ? HEIGHT_CAP : height_r);
  assign height_m1  = height_sat - 1'b1;

  assign col_cur = in_restart_frame ? '0 : col_r;
  assign row_cur = in_restart_frame ? '0 : row_r;
  assign so_cur  = in_restart_frame ? '0 : so_r;

  assign eol     = {1'b0, col_cur} >= pairs_m1;
  assign eof     = eol && (row_cur >= height_m1[scb_pkg::ROW_W-1:0]);
  assign so_inc  = {1'b0, so_cur} + 1'b1;
  assign so_next = (so_inc >= pairs) ? '0 : so_inc[scb_pkg::COL_W-1:0];

  // one restoring step: remainder shifted left with the next dividend bit
  assign step_bit = cmd.step_mod & dvd_r[scb_pkg::COL_W-1];
  assign trial    = {rem_r, step_bit};
  assign ge       = trial >= pairs_r;
  assign rem_step = ge ? scb_pkg::COL_W'(trial - pairs_r) : trial[scb_pkg::COL_W-1:0];

  assign sum_raw  = {1'b0, a_r} + {1'b0, rem_r};
  assign sum_red  = (sum_raw >= pairs_r) ? scb_pkg::COL_W'(sum_raw - pairs_r)
                                         : sum_raw[scb_pkg::COL_W-1:0];

  assign sts.odd_width = odd;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= scb_pkg::WIDTH_RESET;
      height_r <= scb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scb_pkg::REG_LINE_WIDTH:   width_r  <= cfg_data;
        scb_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      so_r  <= '0;
    end else if (cmd.load) begin
      if (odd) begin
        col_r <= col_cur;
        row_r <= row_cur;
        so_r  <= so_cur;
      end else begin
        col_r <= eol ? '0 : col_cur + 1'b1;
        row_r <= eol ? (eof ? '0 : row_cur + 1'b1) : row_cur;
        so_r  <= eof ? so_next : so_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pairs_r  <= pairs;
      eol_r    <= eol;
      eof_r    <= eof;
      err_r    <= odd;
      dvd_r    <= col_cur;
      so_lat_r <= so_cur;
      rem_r    <= '0;
    end else if (cmd.step_mod) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[scb_pkg::COL_W-2:0], 1'b0};
    end else if (cmd.save_a) begin
      a_r   <= rem_r;
      dvd_r <= so_lat_r;
      rem_r <= '0;
    end else if (cmd.sum) begin
      rem_r  <= sum_red;
      quot_r <= '0;
    end else if (cmd.step_bar) begin
      rem_r  <= rem_step;
      quot_r <= {quot_r[scb_pkg::BAR_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word_r       <= err_r ? '0 : scb_pkg::bar_word(quot_r);
      line_last_r  <= eol_r && !err_r;
      frame_last_r <= eof_r && !err_r;
      odd_err_r    <= err_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_pair_word = word_r;
  assign out_line_last       = line_last_r;
  assign out_frame_last      = frame_last_r;
  assign out_odd_width_error = odd_err_r;

endmodule

[design/scrolling_color_bar_generator.sv]
// Top level of the scrolling color bar generator.
// Each word taken on in_word produces one YUYV pixel pair word on out_word,
// in raster order: pairs of a line, lines of a frame. The bars move by one
// pair per frame. restart_frame = 1 makes that word the first pair of a frame
// with zero scroll.
// Configuration: cfg_we with cfg_index 0 (line width in pixels) or 1 (frame
// height in lines), data on cfg_data; write only while no word is in flight.
// Operation: a word is computed by one shared restoring remainder/divide unit,
// one bit per cycle: 11 steps for the column remainder, one save, 11 for the
// scroll remainder, one add, 3 quotient steps for the bar index. The result is
// registered as the sequencer leaves its last step, and in_ready rises with it;
// no new word is taken before the last one is finished. With an odd or zero
// width the sequencer skips the steps and registers the error word in its last
// step.
// The output register lets a new word be accepted while the last result waits;
// a stalled receiver holds the finished word and the sequencer waits in its
// last step until the register frees.
// Reset (rst_n low, synchronous) restores 640x480, clears position and scroll
// and empties the output register.
module scrolling_color_bar_generator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [scb_pkg::IDX_W-1:0] cfg_index,
  input  logic [scb_pkg::CFG_W-1:0] cfg_data,
  scb_in_if.sink                    in_word,
  scb_out_if.source                 out_word
);

  scb_pkg::scb_cmd_t cmd;
  scb_pkg::scb_sts_t sts;
  logic              in_ready;

  assign in_word.ready = in_ready;

  scb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_restart_frame    (in_word.restart_frame),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_word.valid),
    .out_ready           (out_word.ready),
    .out_pixel_pair_word (out_word.pixel_pair_word),
    .out_line_last       (out_word.line_last),
    .out_frame_last      (out_word.frame_last),
    .out_odd_width_error (out_word.odd_width_error)
  );

endmodule

[design/scb_checker.sv]
// Port-level checker for the scrolling color bar generator, bound to the top level.
module scb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [scb_pkg::WORD_W-1:0]  out_pixel_pair_word,
  input logic                        out_line_last,
  input logic                        out_frame_last,
  input logic                        out_odd_width_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_pair_word) && $stable(out_line_last))
    else $error("stalled output word changed");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_odd_width_error |->
      out_pixel_pair_word == '0 && !out_line_last && !out_frame_last)
    else $error("error word carries pattern data");

  a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_line_last)
    else $error("frame end without line end");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken before the first finished");

endmodule

bind scrolling_color_bar_generator scb_checker u_scb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_word.valid),
  .in_ready            (in_word.ready),
  .out_valid           (out_word.valid),
  .out_ready           (out_word.ready),
  .out_pixel_pair_word (out_word.pixel_pair_word),
  .out_line_last       (out_word.line_last),
  .out_frame_last      (out_word.frame_last),
  .out_odd_width_error (out_word.odd_width_error)
);
